FILE: rtl/pixel_mean_variance_stack_top_defines.svh
// Assertion macros for the pixel mean/variance stack.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PIXEL_MEAN_VARIANCE_STACK_TOP_DEFINES_SVH
`define PIXEL_MEAN_VARIANCE_STACK_TOP_DEFINES_SVH

// Same-cycle implication
`define PMVS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PMVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pmvs_pkg.sv
// Shared types, constants and codes for the pixel mean/variance stack.
// No dependencies.
package pmvs_pkg;

  localparam int MAX_PIXELS = 65536;
  localparam int MAX_FRAMES = 4096;
  localparam int PIXEL_BITS = 16;

  localparam int PIX_W  = 16;
  localparam int IDX_W  = 16;
  localparam int SIZE_W = 17;
  localparam int FC_W   = 13;
  localparam int SUM_W  = 28;
  localparam int SQ_W   = 44;
  localparam int QLO_W  = 22;
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 38;
  localparam int DVD_W  = 64;
  localparam int DVS_W  = 26;

  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << PIXEL_BITS) - 64'd1);

  // command codes
  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FRAMES  = 3'd1;
  localparam logic [2:0] ST_LIMIT      = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [PIX_W-1:0] pixel_value;
    logic [IDX_W-1:0] read_index;
  } pmvs_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_fixed;
    logic [VAR_W-1:0]  variance_fixed;
    logic [FC_W-1:0]   frames_used;
    logic [2:0]        status;
  } pmvs_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SWR, S_RLD, S_MUL0, S_MUL1, S_NS, S_DIFF, S_DIVM, S_DIVV, S_RESP
  } pmvs_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic latch;
    logic smp_write;
    logic rd_cap;
    logic mul0;
    logic mul1;
    logic ns;
    logic diff;
    logic mean_start;
    logic var_start;
    logic cap_var;
    logic load_out;
  } pmvs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go_sample;
    logic go_read;
    logic div_done;
    logic out_free;
  } pmvs_stat_t;

endpackage

FILE: rtl/pixel_mean_variance_stack_top.sv
// Per-pixel mean and variance over a stack of frames.
// Input items: cmd 0 pixel sample (raster order), 1 readout of one pixel
//   index, 2 restart of the stack. Every item yields one result item.
// Configuration: cfg_we/cfg_wdata set the frame size; write only while idle.
// One item is in work at a time; in_ready is high only when the sequencer
// is idle. A sample does one store read, then one read-modify-write, and
// its result is loaded; the sequencer then returns to idle for the next
// item. A readout does a registered store read, three multiply/add steps,
// a subtraction, then two 64-step restoring divisions in one shared
// divider (mean, then variance). Other items and rejected samples and
// readouts go from decode straight to loading the result.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and worked on, and it waits in its final step
// until the register is free.
// Reset (rst_n low, synchronous) clears the counters, the sequencer and
// out_valid and sets the frame size to 65536. The stores are not cleared:
// the first frame overwrites them.
// Depends on pmvs_pkg, pmvs_ctrl, pmvs_dp and the defines header.
`include "pixel_mean_variance_stack_top_defines.svh"
module pixel_mean_variance_stack_top import pmvs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pmvs_in_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output pmvs_out_t         out_item,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata
);
  pmvs_cmd_t  cmd;
  pmvs_stat_t stat;

  pmvs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  pmvs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .stat(stat), .out_valid(out_valid),
    .out_ready(out_ready), .out_item(out_item)
  );

  // checks
  `PMVS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "accepted while busy")
  `PMVS_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded result not shown")
  `PMVS_ASSERT_SAME(a_err_zero, out_valid && out_item.status != ST_OK,
                    out_item.mean_fixed == '0 && out_item.variance_fixed == '0,
                    "nonzero values on rejected item")
endmodule

FILE: rtl/pmvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/pmvs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pmvs_pkg.
module pmvs_div import pmvs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             fits;

  // one trial subtraction; the remainder always stays below the divisor
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

FILE: rtl/pmvs_ctrl.sv
// Sequencer for sample, readout and housekeeping items.
// Depends on pmvs_pkg.
module pmvs_ctrl import pmvs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pmvs_stat_t stat,
  output pmvs_cmd_t  cmd
);
  pmvs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.latch = 1'b1;
        if (stat.go_sample)    state_nxt = S_SWR;
        else if (stat.go_read) state_nxt = S_RLD;
        else                   state_nxt = S_RESP;
      end
      S_SWR: begin
        cmd.smp_write = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RLD: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_NS;
      end
      S_NS: begin
        cmd.ns    = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff       = 1'b1;
        cmd.mean_start = 1'b1;
        state_nxt      = S_DIVM;
      end
      S_DIVM: begin
        if (stat.div_done) begin
          cmd.var_start = 1'b1;
          state_nxt     = S_DIVV;
        end
      end
      S_DIVV: begin
        if (stat.div_done) begin
          cmd.cap_var = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

FILE: rtl/pmvs_dp.sv
// Datapath: counters, accumulation stores, readout arithmetic, result register.
// Depends on pmvs_pkg, pmvs_ram and pmvs_div.
module pmvs_dp import pmvs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pmvs_in_t          in_item,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  pmvs_cmd_t         cmd,
  output pmvs_stat_t        stat,
  output logic              out_valid,
  input  logic              out_ready,
  output pmvs_out_t         out_item
);
  localparam int AW   = $clog2(MAX_PIXELS);
  localparam int PA_W = FC_W + QLO_W;
  localparam int PB_W = FC_W + SQ_W - QLO_W;
  localparam int NS_W = FC_W + SQ_W;
  localparam int SS_W = 2 * SUM_W;
  localparam int NN_W = 2 * FC_W;

  logic [SIZE_W-1:0] fpix_r;
  logic [IDX_W-1:0]  pc_r;
  logic [FC_W-1:0]   fc_r;
  pmvs_in_t          item_r;
  logic [2:0]        code_r;
  logic [2*PIX_W-1:0] pp_r;
  logic [SUM_W-1:0]  s_r;
  logic [SQ_W-1:0]   q_r;
  logic [SS_W-1:0]   ss_r;
  logic [PA_W-1:0]   pa_r;
  logic [PB_W-1:0]   pb_r;
  logic [NN_W-1:0]   nn_r;
  logic [NS_W-1:0]   ns_r;
  logic [SS_W-1:0]   diff_r;
  logic [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]  var_r;
  logic              out_valid_r;
  pmvs_out_t         out_item_r;

  logic [SIZE_W-1:0] size;
  logic [PIX_W-1:0]  pix;
  logic [2:0]        code;
  logic [SIZE_W-1:0] pc_plus;
  logic [SUM_W-1:0]  sum_rd, sum_wr;
  logic [SQ_W-1:0]   sq_rd, sq_wr;
  logic [AW-1:0]     raddr;
  logic              div_start, div_done;
  logic [DVD_W-1:0]  dvd, quo;
  logic [DVS_W-1:0]  dvs;

  // effective frame size, sample value and decode
  always_comb begin
    if (fpix_r == '0) size = SIZE_W'(1);
    else if (fpix_r > SIZE_W'(MAX_PIXELS)) size = SIZE_W'(MAX_PIXELS);
    else size = fpix_r;
    pix     = item_r.pixel_value & PIX_MASK;
    pc_plus = {1'b0, pc_r} + 1'b1;
    code    = ST_OK;
    case (item_r.cmd)
      CMD_SAMPLE: begin
        if (fc_r >= FC_W'(MAX_FRAMES)) code = ST_LIMIT;
      end
      CMD_READ: begin
        if (fc_r == '0)                            code = ST_NO_FRAMES;
        else if (pc_r != '0)                       code = ST_INCOMPLETE;
        else if ({1'b0, item_r.read_index} >= size) code = ST_RANGE;
      end
      default: code = ST_OK;
    endcase
    stat.go_sample = (item_r.cmd == CMD_SAMPLE) && (code == ST_OK);
    stat.go_read   = (item_r.cmd == CMD_READ) && (code == ST_OK);
    stat.div_done  = div_done;
    stat.out_free  = !out_valid_r || out_ready;
  end

  // store access
  assign raddr  = (item_r.cmd == CMD_READ) ? AW'(item_r.read_index) : AW'(pc_r);
  assign sum_wr = (fc_r == '0) ? SUM_W'(pix) : sum_rd + SUM_W'(pix);
  assign sq_wr  = (fc_r == '0) ? SQ_W'(pp_r) : sq_rd + SQ_W'(pp_r);

  pmvs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_PIXELS)) u_sum_ram (
    .clk(clk), .we(cmd.smp_write), .waddr(AW'(pc_r)), .wdata(sum_wr),
    .raddr(raddr), .rdata(sum_rd)
  );

  pmvs_ram #(.WIDTH(SQ_W), .DEPTH(MAX_PIXELS)) u_sq_ram (
    .clk(clk), .we(cmd.smp_write), .waddr(AW'(pc_r)), .wdata(sq_wr),
    .raddr(raddr), .rdata(sq_rd)
  );

  // divider: mean first, then variance
  assign div_start = cmd.mean_start || cmd.var_start;
  assign dvd = cmd.var_start ? {diff_r, 8'b0} : DVD_W'({s_r, 8'b0});
  assign dvs = cmd.var_start ? DVS_W'(nn_r) : DVS_W'(fc_r);

  pmvs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(quo)
  );

  // control state: config, counters, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpix_r      <= SIZE_W'(MAX_PIXELS);
      pc_r        <= '0;
      fc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) fpix_r <= cfg_wdata;
      if (cmd.latch && item_r.cmd == CMD_RESTART) begin
        pc_r <= '0;
        fc_r <= '0;
      end
      if (cmd.smp_write) begin
        if (pc_plus >= size) begin
          pc_r <= '0;
          fc_r <= fc_r + 1'b1;
        end else begin
          pc_r <= pc_plus[IDX_W-1:0];
        end
      end
      if (cmd.load_out)  out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.take) item_r <= in_item;
    if (cmd.latch) begin
      code_r <= code;
      mean_r <= '0;
      var_r  <= '0;
      pp_r   <= pix * pix;
    end
    if (cmd.rd_cap) begin
      s_r <= sum_rd;
      q_r <= sq_rd;
    end
    if (cmd.mul0) begin
      ss_r <= s_r * s_r;
      pa_r <= fc_r * q_r[QLO_W-1:0];
      nn_r <= fc_r * fc_r;
    end
    if (cmd.mul1) pb_r <= fc_r * q_r[SQ_W-1:QLO_W];
    if (cmd.ns)   ns_r <= NS_W'(pa_r) + {pb_r, {QLO_W{1'b0}}};
    if (cmd.diff) begin
      diff_r <= (ns_r > NS_W'(ss_r)) ? SS_W'(ns_r - NS_W'(ss_r)) : '0;
    end
    if (cmd.var_start) mean_r <= quo[MEAN_W-1:0];
    if (cmd.cap_var) begin
      var_r <= (quo > DVD_W'({VAR_W{1'b1}})) ? {VAR_W{1'b1}} : quo[VAR_W-1:0];
    end
    if (cmd.load_out) begin
      out_item_r.mean_fixed     <= mean_r;
      out_item_r.variance_fixed <= var_r;
      out_item_r.frames_used    <= fc_r;
      out_item_r.status         <= code_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule

FILE: verif/pixel_mean_variance_stack_top_tb.sv
// Testbench for pixel_mean_variance_stack_top: a directed table, then random stacks of frames.
// Results are checked against an in-bench model of the per-pixel sums and the readout math.
// Depends on pmvs_pkg and the top level RTL.
module pixel_mean_variance_stack_top_tb;
  import pmvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  pmvs_in_t          in_item;
  logic              out_valid;
  logic              out_ready;
  pmvs_out_t         out_item;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  pixel_mean_variance_stack_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // bench copy of the block state
  logic [SUM_W-1:0]  acc_sum [0:MAX_PIXELS-1];
  logic [SQ_W-1:0]   acc_sq  [0:MAX_PIXELS-1];
  bit                stored  [0:MAX_PIXELS-1];
  int unsigned       pix_cnt;
  int unsigned       frm_cnt;
  logic [SIZE_W-1:0] frame_size;

  pmvs_out_t pending_results[$];
  int        errors;
  int        send_idle;
  int        recv_idle;

  // directed table row: either a register write or an item
  typedef struct {
    bit                is_cfg;
    logic [SIZE_W-1:0] cfg_val;
    pmvs_in_t          item;
    bit                typed;
    pmvs_out_t         result;
  } dir_row_t;
  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned active_size();
    if (frame_size == '0) return 1;
    if (frame_size > MAX_PIXELS) return MAX_PIXELS;
    return frame_size;
  endfunction

  // advance the bench state by one item and return the result it causes
  function automatic pmvs_out_t predict_stats(pmvs_in_t it);
    pmvs_out_t   r;
    int unsigned sz;
    int unsigned idx;
    logic [63:0] p, n, s, q, ns, s2, diff, variance_w, mean_w;
    r = '0;
    sz = active_size();
    case (it.cmd)
      CMD_SAMPLE: begin
        if (frm_cnt >= MAX_FRAMES) begin
          r.status = ST_LIMIT;
        end else begin
          p = 64'(it.pixel_value & PIX_MASK);
          idx = pix_cnt % MAX_PIXELS;
          if (frm_cnt == 0) begin
            acc_sum[idx] = SUM_W'(p);
            acc_sq[idx]  = SQ_W'(p * p);
            stored[idx] = 1'b1;
          end else begin
            acc_sum[idx] = SUM_W'(64'(acc_sum[idx]) + p);
            acc_sq[idx]  = SQ_W'(64'(acc_sq[idx]) + p * p);
          end
          if (pix_cnt + 1 >= sz) begin
            pix_cnt = 0;
            frm_cnt++;
          end else begin
            pix_cnt++;
          end
          r.status = ST_OK;
        end
      end
      CMD_READ: begin
        idx = it.read_index;
        if (frm_cnt == 0) r.status = ST_NO_FRAMES;
        else if (pix_cnt != 0) r.status = ST_INCOMPLETE;
        else if (idx >= sz) r.status = ST_RANGE;
        else begin
          n = 64'(frm_cnt);
          s = 64'(acc_sum[idx]);
          q = 64'(acc_sq[idx]);
          ns = n * q;
          s2 = s * s;
          diff = (ns > s2) ? ns - s2 : 64'd0;
          variance_w = (diff << 8) / (n * n);
          mean_w = (s << 8) / n;
          r.mean_fixed = MEAN_W'(mean_w);
          r.variance_fixed = (variance_w > {{(64-VAR_W){1'b0}}, {VAR_W{1'b1}}}) ?
                             {VAR_W{1'b1}} : VAR_W'(variance_w);
          r.status = ST_OK;
        end
      end
      CMD_RESTART: begin
        pix_cnt = 0;
        frm_cnt = 0;
      end
      default: ;
    endcase
    r.frames_used = FC_W'(frm_cnt);
    return r;
  endfunction

  // wait for every outstanding result, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frame_size(logic [SIZE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_size = v;
  endtask

  // offer one item, after a random gap, and hold it until accepted
  task automatic send_item(pmvs_in_t it, bit typed, pmvs_out_t typed_res);
    pmvs_out_t r;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = predict_stats(it);
    pending_results.push_back(typed ? typed_res : r);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic pmvs_in_t mk_item(logic [1:0] c, logic [15:0] v, logic [15:0] i);
    pmvs_in_t it;
    it.cmd = c;
    it.pixel_value = v;
    it.read_index = i;
    return it;
  endfunction

  function automatic pmvs_out_t mk_res(int unsigned frames, logic [2:0] st);
    pmvs_out_t r;
    r = '0;
    r.frames_used = FC_W'(frames);
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] c, logic [15:0] v, logic [15:0] i);
    dir_row_t d;
    d.is_cfg = 0; d.cfg_val = '0; d.item = mk_item(c, v, i); d.typed = 0; d.result = '0;
    dir_rows.push_back(d);
  endfunction

  function automatic void add_typed(logic [1:0] c, logic [15:0] v, logic [15:0] i,
                                    int unsigned frames, logic [2:0] st);
    dir_row_t d;
    d.is_cfg = 0; d.cfg_val = '0; d.item = mk_item(c, v, i); d.typed = 1;
    d.result = mk_res(frames, st);
    dir_rows.push_back(d);
  endfunction

  function automatic void add_cfg(logic [SIZE_W-1:0] v);
    dir_row_t d;
    d.is_cfg = 1; d.cfg_val = v; d.item = '0; d.typed = 0; d.result = '0;
    dir_rows.push_back(d);
  endfunction

  // random item, biased toward complete frames before a readout
  function automatic pmvs_in_t random_item();
    pmvs_in_t it;
    int unsigned roll;
    roll = $urandom_range(99);
    it.pixel_value = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                               : 16'($urandom);
    it.read_index = ($urandom_range(9) == 0) ? 16'($urandom)
                                              : 16'($urandom_range(active_size() - 1));
    if (roll < 3) it.cmd = CMD_RESTART;
    else if (roll < 6) it.cmd = 2'd3;
    else if (roll < 18 && (pix_cnt == 0 || $urandom_range(4) == 0)) it.cmd = CMD_READ;
    else it.cmd = CMD_SAMPLE;
    // a sample must not add onto an entry that was never written
    if (it.cmd == CMD_SAMPLE && frm_cnt != 0 && frm_cnt < MAX_FRAMES && !stored[pix_cnt])
      it.cmd = CMD_RESTART;
    // a readout that would succeed must hit an entry that holds data
    if (it.cmd == CMD_READ && frm_cnt != 0 && pix_cnt == 0 &&
        it.read_index < active_size() && !stored[it.read_index])
      it.read_index = '0;
    return it;
  endfunction

  // receiver: random stall and result check
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding");
          errors++;
        end else begin
          pmvs_out_t e;
          e = pending_results.pop_front();
          if (out_item.mean_fixed !== e.mean_fixed) begin
            $error("mean_fixed expected %0d actual %0d", e.mean_fixed, out_item.mean_fixed);
            errors++;
          end
          if (out_item.variance_fixed !== e.variance_fixed) begin
            $error("variance_fixed expected %0d actual %0d",
                   e.variance_fixed, out_item.variance_fixed);
            errors++;
          end
          if (out_item.frames_used !== e.frames_used) begin
            $error("frames_used expected %0d actual %0d", e.frames_used, out_item.frames_used);
            errors++;
          end
          if (out_item.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_item.status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int wait_cycles;
    int unsigned sz;
    errors = 0;
    send_idle = 0;
    recv_idle = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    pix_cnt = 0;
    frm_cnt = 0;
    frame_size = 17'd65536;
    for (int k = 0; k < MAX_PIXELS; k++) stored[k] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset size, then size 0, small size, then oversized values
    add_typed(CMD_READ, 16'h0000, 16'h0000, 0, ST_NO_FRAMES);
    add_typed(CMD_SAMPLE, 16'hFFFF, 16'h0000, 0, ST_OK);
    add_typed(CMD_READ, 16'h0000, 16'h0000, 0, ST_NO_FRAMES);
    add_typed(2'd3, 16'hFFFF, 16'hFFFF, 0, ST_OK);
    add_typed(CMD_RESTART, 16'h0000, 16'h0000, 0, ST_OK);
    add_cfg(17'd0);
    add_typed(CMD_SAMPLE, 16'h0000, 16'h0000, 1, ST_OK);
    add_typed(CMD_READ, 16'h0000, 16'h0001, 1, ST_RANGE);
    add_row(CMD_READ, 16'h0000, 16'h0000);
    add_row(CMD_SAMPLE, 16'hFFFF, 16'h0000);
    add_row(CMD_SAMPLE, 16'hFFFF, 16'h0000);
    add_row(CMD_READ, 16'h0000, 16'h0000);
    add_typed(CMD_READ, 16'h0000, 16'hFFFF, 3, ST_RANGE);
    add_cfg(17'd3);
    add_typed(CMD_RESTART, 16'h0000, 16'h0000, 0, ST_OK);
    add_row(CMD_SAMPLE, 16'hFFFF, 16'h0000);
    add_row(CMD_SAMPLE, 16'h0000, 16'h0000);
    add_row(CMD_SAMPLE, 16'hFFFF, 16'h0000);
    add_row(CMD_READ, 16'h0000, 16'h0002);
    add_typed(CMD_READ, 16'h0000, 16'h0003, 1, ST_RANGE);
    add_typed(CMD_SAMPLE, 16'h5A5A, 16'h0000, 1, ST_OK);
    add_typed(CMD_READ, 16'h0000, 16'h0000, 1, ST_INCOMPLETE);
    add_cfg(17'h1FFFF);
    add_typed(CMD_SAMPLE, 16'hA5A5, 16'h0000, 1, ST_OK);
    add_cfg(17'd65536);
    add_typed(CMD_RESTART, 16'h0000, 16'h0000, 0, ST_OK);

    send_idle = 14;
    recv_idle = 75;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_frame_size(dir_rows[k].cfg_val);
      else send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].result);
    end

    // random stacks under each idling mode, frame size changed between phases
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 14 : (mode == 1) ? 75 : 0;
      recv_idle = (mode == 0) ? 75 : (mode == 1) ? 14 : 0;
      for (int ph = 0; ph < 8; ph++) begin
        case ($urandom_range(9))
          0: sz = 0;
          1: sz = $urandom_range(300, 20);
          default: sz = $urandom_range(12, 1);
        endcase
        write_frame_size(SIZE_W'(sz));
        if ($urandom_range(1)) send_item(mk_item(CMD_RESTART, '0, '0), 0, '0);
        repeat (80) send_item(random_item(), 0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
